// File: hdl/upe_pkg.sv
// ----------------------------------------------------------------------------
// upe_pkg
// Types, constants and character helpers shared by the URL percent encoder.
// ----------------------------------------------------------------------------
package upe_pkg;

  localparam int unsigned MaxResults = 7;

  localparam logic [7:0] PctChar = 8'h25;
  localparam logic [7:0] Digit2  = 8'h32;
  localparam logic [7:0] Digit5  = 8'h35;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } upe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } upe_out_t;

  // result bytes of one input beat, entry 0 goes out first
  typedef logic [MaxResults-1:0][7:0] upe_seq_t;

  // what the decoder holds back between beats
  typedef enum logic [2:0] {
    PEND_NONE  = 3'b001,
    PEND_PCT   = 3'b010,
    PEND_DIGIT = 3'b100
  } upe_pend_e;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    logic esc;
    esc = (b <= 8'h20) || (b >= 8'h7f);
    case (b)
      8'h22, 8'h3c, 8'h3e, 8'h5c, 8'h5e, 8'h60, 8'h7b, 8'h7c, 8'h7d: esc = 1'b1;
      default: ;
    endcase
    return esc;
  endfunction

  function automatic logic [7:0] hex_up(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

endpackage

// File: hdl/upe_decode.sv
// ----------------------------------------------------------------------------
// upe_decode
// Turns one input beat into its result bytes and keeps the held percent sign
// and hex digit between beats.
// ----------------------------------------------------------------------------
module upe_decode import upe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  upe_in_t    in_beat_i,
  output upe_seq_t   seq_o,
  output logic [2:0] count_o
);

  upe_pend_e  pend_q, pend_d;
  logic [7:0] digit_q, digit_d;

  logic [7:0] b;
  logic       last;
  logic       b_hex;

  // bytes of a beat handled with nothing held
  logic [2:0][7:0] f;
  logic [1:0]      f_n;
  logic            f_hold;

  // bytes flushed from what was held
  logic [3:0][7:0] p;
  logic [2:0]      p_n;
  logic            use_f;

  logic [2:0] idx;

  assign b     = in_beat_i.in_byte;
  assign last  = in_beat_i.in_last;
  assign b_hex = is_hex(b);

  always_comb begin
    f      = '0;
    f_n    = 2'd0;
    f_hold = 1'b0;
    if (b == PctChar && !last) begin
      f_hold = 1'b1;
    end else if (b == PctChar || needs_escape(b)) begin
      f[0] = PctChar;
      f[1] = hex_up(b[7:4]);
      f[2] = hex_up(b[3:0]);
      f_n  = 2'd3;
    end else begin
      f[0] = b;
      f_n  = 2'd1;
    end
  end

  always_comb begin
    p       = '0;
    p_n     = 3'd0;
    use_f   = 1'b0;
    pend_d  = PEND_NONE;
    digit_d = digit_q;
    unique case (pend_q)
      PEND_PCT: begin
        if (b_hex && !last) begin
          pend_d  = PEND_DIGIT;
          digit_d = b;
        end else if (b_hex) begin
          p   = {b, Digit5, Digit2, PctChar};
          p_n = 3'd4;
        end else begin
          p     = {8'h00, Digit5, Digit2, PctChar};
          p_n   = 3'd3;
          use_f = 1'b1;
        end
      end
      PEND_DIGIT: begin
        if (b_hex) begin
          p   = {8'h00, b, digit_q, PctChar};
          p_n = 3'd3;
        end else begin
          p     = {digit_q, Digit5, Digit2, PctChar};
          p_n   = 3'd4;
          use_f = 1'b1;
        end
      end
      default: begin
        use_f = 1'b1;
      end
    endcase
    if (use_f && f_hold) begin
      pend_d = PEND_PCT;
    end
  end

  // flushed bytes first, then the new byte's own
  always_comb begin
    seq_o = '0;
    idx   = 3'd0;
    for (int i = 0; i < MaxResults; i++) begin
      idx = 3'(i) - p_n;
      if (3'(i) < p_n) begin
        seq_o[i] = p[i[1:0]];
      end else if (use_f && idx < 3'd3) begin
        seq_o[i] = f[idx[1:0]];
      end
    end
    count_o = p_n + (use_f ? {1'b0, f_n} : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= PEND_NONE;
      digit_q <= '0;
    end else if (load_i) begin
      pend_q  <= pend_d;
      digit_q <= digit_d;
    end
  end

endmodule

// File: hdl/url_percent_encoder.sv
// ----------------------------------------------------------------------------
// url_percent_encoder
// Percent-encodes a stream of URL bytes, one beat in and one byte out.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one raw byte and a flag for
// the last byte of a string. Output channel: out_valid_o / out_stall_i carry
// one encoded byte and a flag on the last byte the string produces.
// An accepted beat is held in the input register, is decoded into up to
// seven result bytes that are loaded into the result buffer once it is
// free, and its first byte is then shown from that buffer. The buffer
// sends one byte per cycle while out_stall_i is low. A plain byte yields
// one result byte, an escaped one three, and up to seven come out when
// held bytes are flushed; a beat that is only held yields nothing. While
// out_stall_i is low, the output port's one byte per cycle sets the
// rate, and plain text flows at one beat per cycle.
// The input register takes a new beat while the buffer still has bytes
// waiting; when both are full, in_stall_o is raised until the buffer's last
// byte is taken. A stalled output byte holds. Reset empties both registers
// and drops any held percent sign or digit.
// ----------------------------------------------------------------------------
module url_percent_encoder import upe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  upe_in_t  in_beat_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output upe_out_t out_beat_o
);

  logic       in_vld_q;
  upe_in_t    in_q;
  upe_seq_t   seq_q, dec_seq;
  logic [2:0] cnt_q, dec_cnt;
  logic [2:0] rd_q;
  logic       last_q;

  logic take, buf_free, load, accept;

  assign take     = out_valid_o && !out_stall_i;
  assign buf_free = (cnt_q == 3'd0) || (cnt_q == 3'd1 && take);
  assign load     = in_vld_q && buf_free;
  assign in_stall_o = in_vld_q && !buf_free;
  assign accept   = in_valid_i && !in_stall_o;

  upe_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .in_beat_i(in_q),
    .seq_o   (dec_seq),
    .count_o (dec_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load) begin
      cnt_q <= dec_cnt;
      rd_q  <= '0;
    end else if (take) begin
      cnt_q <= cnt_q - 3'd1;
      rd_q  <= rd_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      seq_q  <= dec_seq;
      last_q <= in_q.in_last;
    end
  end

  assign out_valid_o         = (cnt_q != 3'd0);
  assign out_beat_o.out_byte = seq_q[rd_q];
  assign out_beat_o.out_last = last_q && (cnt_q == 3'd1);

endmodule

// File: hdl/upe_checker.sv
// ----------------------------------------------------------------------------
// upe_checker
// Port-level checks on the URL percent encoder, bound to the top level.
// ----------------------------------------------------------------------------
module upe_checker import upe_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input upe_in_t  in_beat_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input upe_out_t out_beat_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled output beat changed");

  // input stalls only while the result buffer has bytes waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result buffer");

  // a new burst of output starts only after an accepted beat has passed the input register and the result buffer
  a_out_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output started without an accepted beat");

endmodule

bind url_percent_encoder upe_checker u_upe_checker (.*);
